// ----- hw/rtl/lcm_pkg.sv -----
// ----------------------------------------------------------------------------
// lcm_pkg
// Types, codes and reset values shared by the link connection manager.
// ----------------------------------------------------------------------------
package lcm_pkg;

    // apb address width: three 32-bit registers at 4-byte spacing
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BACKOFF_UNIT = 2'd0;
    localparam logic [1:0] REG_BACKOFF_CAP  = 2'd1;
    localparam logic [1:0] REG_DOUBLING_LIM = 2'd2;

    // register reset values
    localparam logic [15:0] BACKOFF_UNIT_RST = 16'd1000;
    localparam logic [7:0]  BACKOFF_CAP_RST  = 8'd60;
    localparam logic [2:0]  DOUBLING_LIM_RST = 3'd6;

    // event codes
    typedef enum logic [3:0] {
        EV_START           = 4'd0,
        EV_CREDS_FOUND     = 4'd1,
        EV_NO_CREDS        = 4'd2,
        EV_PROV_STARTED    = 4'd3,
        EV_PROV_OK         = 4'd4,
        EV_PROV_FAILED     = 4'd5,
        EV_PROV_STOPPED    = 4'd6,
        EV_REPROVISION     = 4'd7,
        EV_LINK_STARTED    = 4'd8,
        EV_CONNECTED       = 4'd9,
        EV_DISCONNECTED    = 4'd10,
        EV_BACKOFF_EXPIRED = 4'd11
    } event_t;

    // connection states
    typedef enum logic [3:0] {
        ST_INIT       = 4'd0,
        ST_NO_CREDS   = 4'd1,
        ST_PROV       = 4'd2,
        ST_STARTING   = 4'd3,
        ST_CONNECTING = 4'd4,
        ST_CONNECTED  = 4'd5,
        ST_BACKOFF    = 4'd6,
        ST_REPROV     = 4'd7,
        ST_ERROR      = 4'd8
    } state_t;

    // application notices
    typedef enum logic [1:0] {
        NOTICE_NONE         = 2'd0,
        NOTICE_CONNECTED    = 2'd1,
        NOTICE_DISCONNECTED = 2'd2
    } notice_t;

    // one result item
    typedef struct packed {
        logic [3:0]  state_out;
        logic        state_changed;
        logic        unexpected_event;
        logic [1:0]  app_notice;
        logic        start_provisioning;
        logic        stop_link_and_reprovision;
        logic        attempt_reconnect;
        logic        start_backoff_timer;
        logic        cancel_backoff_timer;
        logic [23:0] backoff_delay_ms;
    } result_t;

endpackage

// ----- hw/rtl/lcm_if.sv -----
// ----------------------------------------------------------------------------
// lcm_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface lcm_event_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

interface lcm_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  state_out;
    logic        state_changed;
    logic        unexpected_event;
    logic [1:0]  app_notice;
    logic        start_provisioning;
    logic        stop_link_and_reprovision;
    logic        attempt_reconnect;
    logic        start_backoff_timer;
    logic        cancel_backoff_timer;
    logic [23:0] backoff_delay_ms;

    modport source (
        output valid, output state_out, output state_changed, output unexpected_event,
        output app_notice, output start_provisioning, output stop_link_and_reprovision,
        output attempt_reconnect, output start_backoff_timer, output cancel_backoff_timer,
        output backoff_delay_ms, input ready
    );
    modport sink (
        input valid, input state_out, input state_changed, input unexpected_event,
        input app_notice, input start_provisioning, input stop_link_and_reprovision,
        input attempt_reconnect, input start_backoff_timer, input cancel_backoff_timer,
        input backoff_delay_ms, output ready
    );
endinterface

// ----- hw/rtl/link_connection_manager_fsm.sv -----
// ----------------------------------------------------------------------------
// link_connection_manager_fsm
// Event-driven link connection manager with exponential backoff delay.
// ----------------------------------------------------------------------------
// path: an accepted event passes the input register, then the result register
// throughput: one event item per cycle while results are taken; the 8x16 backoff multiply and the
//   next-state decode sit between the input register and the result register
// reset: rst_n async active low; state init, retry count 0, registers to
//   unit 1000 ms, cap 60 units, doubling limit 6; both stages empty
// ----------------------------------------------------------------------------
module link_connection_manager_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcm_pkg::PADDR_W-1:0] paddr,
    input  logic [lcm_pkg::PDATA_W-1:0] pwdata,
    output logic [lcm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    lcm_event_if.sink                   events,
    lcm_result_if.source                results
);
    import lcm_pkg::*;

    // configuration registers
    logic [15:0] unit_reg;
    logic [7:0]  cap_reg;
    logic [2:0]  limit_reg;

    // input stage
    logic        in_valid_reg;
    logic [3:0]  in_code_reg;

    // result stage
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    // connection state
    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  retry_reg;
    logic [2:0]  retry_next;

    logic        cfg_wr;
    logic        advance;

    // decode signals
    event_t      ev;
    logic        bad;
    logic        reprov;
    logic        reconnect;
    logic        tstop;
    logic        backoff;
    logic        clear_after;
    logic        retry_clear;
    logic        retry_below;
    logic [7:0]  pow_units;
    logic [7:0]  units;
    logic [23:0] delay;
    notice_t     notice;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg  <= BACKOFF_UNIT_RST;
            cap_reg   <= BACKOFF_CAP_RST;
            limit_reg <= DOUBLING_LIM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BACKOFF_UNIT: unit_reg  <= pwdata[15:0];
                REG_BACKOFF_CAP:  cap_reg   <= pwdata[7:0];
                REG_DOUBLING_LIM: limit_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_BACKOFF_UNIT: prdata = {16'd0, unit_reg};
            REG_BACKOFF_CAP:  prdata = {24'd0, cap_reg};
            REG_DOUBLING_LIM: prdata = {29'd0, limit_reg};
            default:          prdata = '0;
        endcase
    end

    // handshake: result stage loads when empty or drained
    assign advance      = !out_valid_reg || results.ready;
    assign events.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            in_valid_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.ready && events.valid)
        begin
            in_code_reg <= events.event_code;
        end
    end

    // next state and action decode
    always_comb
    begin
        ev          = event_t'(in_code_reg);
        state_next  = state_reg;
        bad         = 1'b0;
        reprov      = 1'b0;
        reconnect   = 1'b0;
        tstop       = 1'b0;
        backoff     = 1'b0;
        clear_after = 1'b0;
        retry_clear = 1'b0;

        if (in_code_reg > EV_BACKOFF_EXPIRED)
        begin
            bad = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    case (ev) inside
                        EV_CREDS_FOUND: state_next = ST_STARTING;
                        EV_NO_CREDS:    state_next = ST_NO_CREDS;
                        EV_START:       ;
                        default:        bad = 1'b1;
                    endcase
                end
                ST_NO_CREDS:
                begin
                    if (ev == EV_PROV_STARTED)
                        state_next = ST_PROV;
                    else
                        bad = 1'b1;
                end
                ST_PROV:
                begin
                    case (ev) inside
                        EV_PROV_OK:                      state_next = ST_STARTING;
                        EV_PROV_FAILED, EV_PROV_STOPPED: state_next = ST_NO_CREDS;
                        EV_REPROVISION:                  ;
                        default:                         bad = 1'b1;
                    endcase
                end
                ST_STARTING:
                begin
                    case (ev) inside
                        EV_LINK_STARTED: state_next = ST_CONNECTING;
                        EV_REPROVISION:
                        begin
                            state_next = ST_REPROV;
                            reprov     = 1'b1;
                        end
                        default:         bad = 1'b1;
                    endcase
                end
                ST_CONNECTING:
                begin
                    case (ev) inside
                        EV_CONNECTED:
                        begin
                            state_next  = ST_CONNECTED;
                            retry_clear = 1'b1;
                        end
                        EV_DISCONNECTED: backoff = 1'b1;
                        EV_REPROVISION:
                        begin
                            state_next = ST_REPROV;
                            reprov     = 1'b1;
                        end
                        default:         bad = 1'b1;
                    endcase
                end
                ST_CONNECTED:
                begin
                    case (ev) inside
                        EV_DISCONNECTED:
                        begin
                            backoff     = 1'b1;
                            clear_after = 1'b1;
                        end
                        EV_REPROVISION:
                        begin
                            state_next = ST_REPROV;
                            reprov     = 1'b1;
                        end
                        EV_PROV_STARTED, EV_PROV_OK, EV_PROV_STOPPED, EV_CONNECTED: ;
                        default: bad = 1'b1;
                    endcase
                end
                ST_BACKOFF:
                begin
                    case (ev) inside
                        EV_BACKOFF_EXPIRED: reconnect = 1'b1;
                        EV_DISCONNECTED:    backoff   = 1'b1;
                        EV_CONNECTED:
                        begin
                            state_next  = ST_CONNECTED;
                            retry_clear = 1'b1;
                        end
                        EV_REPROVISION:
                        begin
                            tstop      = 1'b1;
                            state_next = ST_REPROV;
                            reprov     = 1'b1;
                        end
                        default:            bad = 1'b1;
                    endcase
                end
                ST_REPROV:
                begin
                    case (ev) inside
                        EV_PROV_OK:                      state_next = ST_STARTING;
                        EV_PROV_FAILED, EV_PROV_STOPPED: state_next = ST_NO_CREDS;
                        EV_CONNECTED:                    state_next = ST_CONNECTED;
                        EV_PROV_STARTED, EV_LINK_STARTED,
                        EV_DISCONNECTED, EV_REPROVISION: ;
                        default:                         bad = 1'b1;
                    endcase
                end
                ST_ERROR:
                begin
                    bad = 1'b1;
                end
                default:
                begin
                    // unreachable state codes: only a reprovision moves on
                    if (ev == EV_REPROVISION)
                    begin
                        state_next = ST_REPROV;
                        reprov     = 1'b1;
                    end
                end
            endcase
        end

        if (backoff)
        begin
            state_next = ST_BACKOFF;
        end
    end

    // backoff delay from the count before it is raised
    assign retry_below = retry_reg < limit_reg;
    assign pow_units   = 8'd1 << retry_reg;
    assign units       = !retry_below ? cap_reg :
                         (pow_units > cap_reg) ? cap_reg : pow_units;
    assign delay       = 24'(units) * 24'(unit_reg);

    // retry count update
    always_comb
    begin
        retry_next = retry_reg;
        if (retry_clear)
        begin
            retry_next = '0;
        end
        if (backoff)
        begin
            if (retry_below)
                retry_next = retry_reg + 3'd1;
            if (clear_after)
                retry_next = '0;
        end
    end

    // notice follows the event code in every state
    always_comb
    begin
        case (in_code_reg)
            EV_CONNECTED:    notice = NOTICE_CONNECTED;
            EV_DISCONNECTED: notice = NOTICE_DISCONNECTED;
            default:         notice = NOTICE_NONE;
        endcase
    end

    // result item assembly
    always_comb
    begin
        out_next.state_out                 = state_next;
        out_next.state_changed             = state_next != state_reg;
        out_next.unexpected_event          = bad;
        out_next.app_notice                = notice;
        out_next.start_provisioning        = (state_next == ST_NO_CREDS) &&
                                             (state_reg != ST_NO_CREDS);
        out_next.stop_link_and_reprovision = reprov;
        out_next.attempt_reconnect         = reconnect;
        out_next.start_backoff_timer       = backoff;
        out_next.cancel_backoff_timer      = tstop;
        out_next.backoff_delay_ms          = backoff ? delay : 24'd0;
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            retry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
                retry_reg <= retry_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    // result channel
    assign results.valid                     = out_valid_reg;
    assign results.state_out                 = out_reg.state_out;
    assign results.state_changed             = out_reg.state_changed;
    assign results.unexpected_event          = out_reg.unexpected_event;
    assign results.app_notice                = out_reg.app_notice;
    assign results.start_provisioning        = out_reg.start_provisioning;
    assign results.stop_link_and_reprovision = out_reg.stop_link_and_reprovision;
    assign results.attempt_reconnect         = out_reg.attempt_reconnect;
    assign results.start_backoff_timer       = out_reg.start_backoff_timer;
    assign results.cancel_backoff_timer      = out_reg.cancel_backoff_timer;
    assign results.backoff_delay_ms          = out_reg.backoff_delay_ms;

    // held state tracks the newest result
    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.state_out == state_reg))
        else $error("state register differs from newest result");

    // a flagged event never moves the state
    a_unexpected_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.unexpected_event) |-> !out_reg.state_changed)
        else $error("unexpected event changed state");

    // delay only travels with a timer start
    a_delay_with_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.start_backoff_timer) |-> (out_reg.backoff_delay_ms == 24'd0))
        else $error("backoff delay without timer start");

    // a timer start always lands in backoff
    a_start_in_backoff: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.start_backoff_timer) |-> (out_reg.state_out == ST_BACKOFF))
        else $error("timer start outside backoff state");

endmodule

// ----- test/tb_link_connection_manager_fsm.sv -----
// ----------------------------------------------------------------------------
// tb_link_connection_manager_fsm
// Self-checking bench for the link connection manager. A directed walk
// through every reachable state comes first. Random event sequences follow,
// mostly legal for the state the block is in, under several backoff register
// settings. Each result item is checked against the bench's own state machine.
// ----------------------------------------------------------------------------
module tb_link_connection_manager_fsm;
    import lcm_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 150;

    // codes above the defined event set
    localparam logic [3:0] EV_RESERVED_LO = 4'd12;
    localparam logic [3:0] EV_RESERVED_HI = 4'd15;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    lcm_event_if ev();
    lcm_result_if res();

    link_connection_manager_fsm dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .events  (ev),
        .results (res)
    );

    // shadow of the block's state and backoff registers
    state_t      conn_state = ST_INIT;
    logic [2:0]  retries = 3'd0;
    logic [15:0] unit_ms = BACKOFF_UNIT_RST;
    logic [7:0]  cap_units = BACKOFF_CAP_RST;
    logic [2:0]  dbl_limit = DOUBLING_LIM_RST;

    logic [3:0] event_backlog [$];
    result_t    due_results [$];
    int         items_left = 0;
    int         mismatches = 0;
    int         send_gap;
    int         recv_stall;
    bit         no_idle = 1'b0;
    bit         hold_go = 1'b0;
    logic       long_hold = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // next state, strobes and delay for one event; advances the shadow state
    function automatic result_t step_connection(input logic [3:0] code);
        result_t    r;
        state_t     prev;
        state_t     nxt;
        logic       bad;
        logic       backoff;
        logic       clear_after;
        logic [7:0] units;
        r = '0;
        prev = conn_state;
        nxt = prev;
        bad = 1'b0;
        backoff = 1'b0;
        clear_after = 1'b0;
        if (code == EV_CONNECTED)
            r.app_notice = NOTICE_CONNECTED;
        else if (code == EV_DISCONNECTED)
            r.app_notice = NOTICE_DISCONNECTED;
        else
            r.app_notice = NOTICE_NONE;
        if (code > EV_BACKOFF_EXPIRED)
            bad = 1'b1;
        else
        begin
            case (prev)
                ST_INIT:
                    if (code == EV_CREDS_FOUND) nxt = ST_STARTING;
                    else if (code == EV_NO_CREDS) nxt = ST_NO_CREDS;
                    else if (code != EV_START) bad = 1'b1;
                ST_NO_CREDS:
                    if (code == EV_PROV_STARTED) nxt = ST_PROV;
                    else bad = 1'b1;
                ST_PROV:
                    if (code == EV_PROV_OK) nxt = ST_STARTING;
                    else if (code == EV_PROV_FAILED || code == EV_PROV_STOPPED) nxt = ST_NO_CREDS;
                    else if (code != EV_REPROVISION) bad = 1'b1;
                ST_STARTING:
                    if (code == EV_LINK_STARTED) nxt = ST_CONNECTING;
                    else if (code == EV_REPROVISION)
                    begin
                        nxt = ST_REPROV;
                        r.stop_link_and_reprovision = 1'b1;
                    end
                    else bad = 1'b1;
                ST_CONNECTING:
                    if (code == EV_CONNECTED)
                    begin
                        nxt = ST_CONNECTED;
                        retries = 3'd0;
                    end
                    else if (code == EV_DISCONNECTED) backoff = 1'b1;
                    else if (code == EV_REPROVISION)
                    begin
                        nxt = ST_REPROV;
                        r.stop_link_and_reprovision = 1'b1;
                    end
                    else bad = 1'b1;
                ST_CONNECTED:
                    if (code == EV_DISCONNECTED)
                    begin
                        backoff = 1'b1;
                        clear_after = 1'b1;
                    end
                    else if (code == EV_REPROVISION)
                    begin
                        nxt = ST_REPROV;
                        r.stop_link_and_reprovision = 1'b1;
                    end
                    else if (code != EV_PROV_STARTED && code != EV_PROV_OK &&
                             code != EV_PROV_STOPPED && code != EV_CONNECTED)
                        bad = 1'b1;
                ST_BACKOFF:
                    if (code == EV_BACKOFF_EXPIRED) r.attempt_reconnect = 1'b1;
                    else if (code == EV_DISCONNECTED) backoff = 1'b1;
                    else if (code == EV_CONNECTED)
                    begin
                        nxt = ST_CONNECTED;
                        retries = 3'd0;
                    end
                    else if (code == EV_REPROVISION)
                    begin
                        r.cancel_backoff_timer = 1'b1;
                        nxt = ST_REPROV;
                        r.stop_link_and_reprovision = 1'b1;
                    end
                    else bad = 1'b1;
                ST_REPROV:
                    if (code == EV_PROV_OK) nxt = ST_STARTING;
                    else if (code == EV_PROV_FAILED || code == EV_PROV_STOPPED) nxt = ST_NO_CREDS;
                    else if (code == EV_CONNECTED) nxt = ST_CONNECTED;
                    else if (code != EV_PROV_STARTED && code != EV_LINK_STARTED &&
                             code != EV_DISCONNECTED && code != EV_REPROVISION)
                        bad = 1'b1;
                ST_ERROR:
                    bad = 1'b1;
                default:
                    if (code == EV_REPROVISION)
                    begin
                        nxt = ST_REPROV;
                        r.stop_link_and_reprovision = 1'b1;
                    end
            endcase
        end
        // exponential backoff, delay taken before the retry count rises
        if (backoff)
        begin
            if (retries < dbl_limit && (8'd1 << retries) < cap_units)
                units = 8'd1 << retries;
            else
                units = cap_units;
            r.start_backoff_timer = 1'b1;
            r.backoff_delay_ms = 24'(units) * 24'(unit_ms);
            if (retries < dbl_limit)
                retries = retries + 3'd1;
            nxt = ST_BACKOFF;
            if (clear_after)
                retries = 3'd0;
        end
        conn_state = nxt;
        r.state_out = nxt;
        r.state_changed = (nxt != prev);
        r.unexpected_event = bad;
        r.start_provisioning = (nxt == ST_NO_CREDS && prev != ST_NO_CREDS);
        return r;
    endfunction

    // an event that the given state is likely to accept
    function automatic logic [3:0] plausible_event(input state_t s);
        case (s)
            ST_INIT:
                return $urandom_range(0, 1) ? EV_CREDS_FOUND : EV_NO_CREDS;
            ST_NO_CREDS:
                return EV_PROV_STARTED;
            ST_PROV:
                case ($urandom_range(0, 3))
                    0: return EV_PROV_OK;
                    1: return EV_PROV_FAILED;
                    2: return EV_PROV_STOPPED;
                    default: return EV_REPROVISION;
                endcase
            ST_STARTING:
                return ($urandom_range(0, 4) == 0) ? EV_REPROVISION : EV_LINK_STARTED;
            ST_CONNECTING:
                case ($urandom_range(0, 4))
                    0, 1: return EV_CONNECTED;
                    2, 3: return EV_DISCONNECTED;
                    default: return EV_REPROVISION;
                endcase
            ST_CONNECTED:
                case ($urandom_range(0, 7))
                    0, 1, 2: return EV_DISCONNECTED;
                    3: return EV_REPROVISION;
                    4: return EV_CONNECTED;
                    5: return EV_PROV_OK;
                    6: return EV_PROV_STARTED;
                    default: return EV_PROV_STOPPED;
                endcase
            ST_BACKOFF:
                case ($urandom_range(0, 6))
                    0, 1, 2: return EV_DISCONNECTED;
                    3, 4: return EV_BACKOFF_EXPIRED;
                    5: return EV_CONNECTED;
                    default: return EV_REPROVISION;
                endcase
            ST_REPROV:
                case ($urandom_range(0, 7))
                    0: return EV_PROV_OK;
                    1: return EV_PROV_FAILED;
                    2: return EV_PROV_STOPPED;
                    3: return EV_CONNECTED;
                    4: return EV_PROV_STARTED;
                    5: return EV_LINK_STARTED;
                    6: return EV_DISCONNECTED;
                    default: return EV_REPROVISION;
                endcase
            default:
                return 4'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [23:0] want,
                                 input logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // register write through the apb port, shadow updated at the same time
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BACKOFF_UNIT: unit_ms = value[15:0];
            REG_BACKOFF_CAP:  cap_units = value[7:0];
            REG_DOUBLING_LIM: dbl_limit = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_backoff(input logic [15:0] unit, input logic [7:0] cap,
                               input logic [2:0] limit);
        write_reg(REG_BACKOFF_UNIT, {16'd0, unit});
        write_reg(REG_BACKOFF_CAP, {24'd0, cap});
        write_reg(REG_DOUBLING_LIM, {29'd0, limit});
    endtask

    // wait until every item is in and every result is out
    task automatic wait_settled;
        while (items_left != 0 || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random sequences, mostly legal for the state reached so far
    task automatic run_random(input int n);
        state_t     saved_state;
        logic [2:0] saved_retries;
        logic [3:0] code;
        saved_state = conn_state;
        saved_retries = retries;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                code = 4'($urandom_range(0, 15));
            else
                code = plausible_event(conn_state);
            event_backlog.push_back(code);
            void'(step_connection(code));
        end
        conn_state = saved_state;
        retries = saved_retries;
        items_left += n;
        wait_settled();
    endtask

    // event driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev.valid <= 1'b0;
            ev.event_code <= '0;
            send_gap = 0;
        end
        else
        begin
            if (ev.valid && ev.ready)
            begin
                due_results.push_back(step_connection(ev.event_code));
                items_left--;
            end
            if (!ev.valid || ev.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    ev.valid <= 1'b0;
                end
                else if (event_backlog.size() > 0)
                begin
                    ev.valid <= 1'b1;
                    ev.event_code <= event_backlog.pop_front();
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 6);
                end
                else
                    ev.valid <= 1'b0;
            end
        end
    end

    // result monitor and ready control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result item with no expectation, actual state_out %0d",
                             $time, res.state_out);
                    mismatches++;
                end
                else
                begin
                    result_t want;
                    want = due_results.pop_front();
                    compare_field("state_out", 24'(want.state_out), 24'(res.state_out));
                    compare_field("state_changed", 24'(want.state_changed),
                                  24'(res.state_changed));
                    compare_field("unexpected_event", 24'(want.unexpected_event),
                                  24'(res.unexpected_event));
                    compare_field("app_notice", 24'(want.app_notice), 24'(res.app_notice));
                    compare_field("start_provisioning", 24'(want.start_provisioning),
                                  24'(res.start_provisioning));
                    compare_field("stop_link_and_reprovision",
                                  24'(want.stop_link_and_reprovision),
                                  24'(res.stop_link_and_reprovision));
                    compare_field("attempt_reconnect", 24'(want.attempt_reconnect),
                                  24'(res.attempt_reconnect));
                    compare_field("start_backoff_timer", 24'(want.start_backoff_timer),
                                  24'(res.start_backoff_timer));
                    compare_field("cancel_backoff_timer", 24'(want.cancel_backoff_timer),
                                  24'(res.cancel_backoff_timer));
                    compare_field("backoff_delay_ms", want.backoff_delay_ms,
                                  res.backoff_delay_ms);
                end
            end
            if (long_hold)
                res.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                res.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(1, 6) - 1;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // stimulus sequence
    initial
    begin
        logic [3:0] opening [25];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ev.valid = 1'b0;
        ev.event_code = '0;
        res.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk under reset register values
        opening = '{EV_RESERVED_HI, EV_START, EV_PROV_FAILED, EV_NO_CREDS, EV_PROV_STARTED,
                    EV_REPROVISION, EV_PROV_STOPPED, EV_PROV_STARTED, EV_PROV_OK,
                    EV_LINK_STARTED, EV_DISCONNECTED, EV_BACKOFF_EXPIRED, EV_DISCONNECTED,
                    EV_RESERVED_LO, EV_CONNECTED, EV_PROV_STOPPED, EV_DISCONNECTED,
                    EV_REPROVISION, EV_DISCONNECTED, EV_CONNECTED, EV_REPROVISION,
                    EV_PROV_OK, EV_REPROVISION, EV_PROV_FAILED, EV_START};
        foreach (opening[i])
            event_backlog.push_back(opening[i]);
        items_left += 25;
        wait_settled();

        // largest delay settings, with the receiver held off for a while
        set_backoff(16'hFFFF, 8'hFF, 3'd7);
        hold_go = 1'b1;
        run_random(250);

        // smallest legal settings, no doubling at all
        set_backoff(16'd1, 8'd1, 3'd0);
        run_random(200);

        // zero unit and zero cap
        set_backoff(16'd0, 8'd0, 3'd3);
        run_random(150);

        // small cap clips the doubling
        set_backoff(16'($urandom_range(1, 65535)), 8'd5, 3'd7);
        run_random(250);

        set_backoff(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                    3'($urandom_range(0, 7)));
        run_random(200);

        // back to reset values, full rate on both sides
        no_idle = 1'b1;
        set_backoff(BACKOFF_UNIT_RST, BACKOFF_CAP_RST, DOUBLING_LIM_RST);
        run_random(150);

        if (mismatches == 0)
            $display("link_connection_manager_fsm regression: pass");
        else
            $display("link_connection_manager_fsm regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #(2 * CLK_HALF * 200000);
        $display("link_connection_manager_fsm regression: fail");
        $finish;
    end

endmodule
